// ===== sv/mmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmdc_pkg
// Shared types and constants for the motor mode drive controller.
// ----------------------------------------------------------------------------
package mmdc_pkg;

  // Drive mode, advanced by a debounced button press
  typedef enum logic [2:0] {
    MODE_STOP    = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_REVERSE = 3'd2,
    MODE_LEFT    = 3'd3,
    MODE_RIGHT   = 3'd4
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_TICKS  = 2'd0;
  localparam logic [1:0] CFG_LIGHT_INVERT    = 2'd1;
  localparam logic [1:0] CFG_MOTOR_TWO_INV   = 2'd2;
  localparam logic [1:0] CFG_BUTTON_ACTIVE   = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W     = 32;

  // H-bridge input levels for both motors
  typedef struct packed {
    logic m1_fwd;
    logic m1_rev;
    logic m2_fwd;
    logic m2_rev;
  } bridge_t;

endpackage

// ===== sv/mmdc_duty_scale.sv =====
// ----------------------------------------------------------------------------
// mmdc_duty_scale
// Scales a light sample to PWM duty: floor(s * DutyMax / SampleMax).
// ----------------------------------------------------------------------------
module mmdc_duty_scale #(
  parameter int SAMPLE_BITS = 12,
  parameter int DUTY_BITS   = 10
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   invert,
  input  logic                   enable,
  output logic [DUTY_BITS-1:0]   duty
);

  localparam int PW = SAMPLE_BITS + DUTY_BITS;
  localparam logic [PW-1:0] SampleMax = PW'((1 << SAMPLE_BITS) - 1);
  localparam logic [PW-1:0] DutyMax   = PW'((1 << DUTY_BITS) - 1);
  // enough end-around folds for any width pair in range to leave r < 2*SampleMax
  localparam int NumFolds = 4;

  logic [SAMPLE_BITS-1:0] s;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          r;
  logic [PW-1:0]          q;

  assign s    = invert ? (SampleMax[SAMPLE_BITS-1:0] - sample) : sample;
  assign prod = PW'(s) * DutyMax;

  // divide by 2^S - 1: p = a*2^S + b = a*(2^S - 1) + (a + b), fold the remainder
  always_comb begin
    r = prod;
    q = '0;
    for (int i = 0; i < NumFolds; i++) begin
      q = q + (r >> SAMPLE_BITS);
      r = (r >> SAMPLE_BITS) + (r & SampleMax);
    end
    if (r >= SampleMax) begin
      q = q + PW'(1);
    end
    duty = enable ? q[DUTY_BITS-1:0] : '0;
  end

endmodule

// ===== sv/mmdc_bridge_map.sv =====
// ----------------------------------------------------------------------------
// mmdc_bridge_map
// Maps drive mode to H-bridge input levels, with optional second motor swap.
// ----------------------------------------------------------------------------
module mmdc_bridge_map
  import mmdc_pkg::*;
(
  input  mode_t   mode,
  input  logic    m2_invert,
  output bridge_t bridge
);

  logic m2_fwd_raw;
  logic m2_rev_raw;

  always_comb begin
    bridge.m1_fwd = 1'b0;
    bridge.m1_rev = 1'b0;
    m2_fwd_raw    = 1'b0;
    m2_rev_raw    = 1'b0;
    case (mode)
      MODE_FORWARD: begin
        bridge.m1_fwd = 1'b1;
        m2_fwd_raw    = 1'b1;
      end
      MODE_REVERSE: begin
        bridge.m1_rev = 1'b1;
        m2_rev_raw    = 1'b1;
      end
      MODE_LEFT: begin
        bridge.m1_rev = 1'b1;
        m2_fwd_raw    = 1'b1;
      end
      MODE_RIGHT: begin
        bridge.m1_fwd = 1'b1;
        m2_rev_raw    = 1'b1;
      end
      default: begin
      end
    endcase
    // reversing a motor swaps its bridge inputs; stopped stays both low
    bridge.m2_fwd = m2_invert ? m2_rev_raw : m2_fwd_raw;
    bridge.m2_rev = m2_invert ? m2_fwd_raw : m2_rev_raw;
  end

endmodule

// ===== sv/motor_mode_drive_controller_top.sv =====
// ----------------------------------------------------------------------------
// motor_mode_drive_controller_top
// Debounced button mode cycler with two-motor H-bridge drive and PWM duty.
// ----------------------------------------------------------------------------
// Takes one poll word per clock while in_stall is low and returns one result
// word per poll. Mode, debounce state and duty are computed in a single
// combinational pass from the poll and the state registers, then written to
// the output register; a one-word skid register behind it lets a poll be
// accepted while a result is still stalled. in_stall rises only when both
// are full. Sustained rate is one poll per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module motor_mode_drive_controller_top
  import mmdc_pkg::*;
#(
  parameter int DUTY_BITS   = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // poll input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_light_sample,
  input  logic                   in_obstacle_level,
  input  logic                   in_button_level,
  input  logic [TICK_W-1:0]      in_now_tick,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_drive_mode,
  output logic                   out_motor_one_fwd,
  output logic                   out_motor_one_rev,
  output logic                   out_motor_two_fwd,
  output logic                   out_motor_two_rev,
  output logic [DUTY_BITS-1:0]   out_pwm_duty
);

  // configuration registers
  logic [CFG_DATA_W-1:0] debounce_ticks_r;
  logic                  light_invert_r;
  logic                  m2_invert_r;
  logic                  button_active_r;

  // debounce and mode state
  mode_t             mode_r, mode_nxt;
  logic              last_raw_r, last_raw_nxt;
  logic              stable_r, stable_nxt;
  logic [TICK_W-1:0] last_change_r, last_change_nxt;
  logic [TICK_W-1:0] held_ticks;

  // output register and skid
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  mode_t                out_mode_r, skid_mode_r;
  bridge_t              out_bridge_r, skid_bridge_r;
  logic [DUTY_BITS-1:0] out_duty_r, skid_duty_r;

  logic                 in_acc;
  logic                 out_take;
  logic                 out_load;
  bridge_t              res_bridge;
  logic [DUTY_BITS-1:0] res_duty;
  logic                 res_active;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign out_load = !out_valid_r || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= CFG_DATA_W'(40);
      light_invert_r   <= 1'b0;
      m2_invert_r      <= 1'b1;
      button_active_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata;
        CFG_LIGHT_INVERT:   light_invert_r   <= cfg_wdata[0];
        CFG_MOTOR_TWO_INV:  m2_invert_r      <= cfg_wdata[0];
        CFG_BUTTON_ACTIVE:  button_active_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // mode state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_STOP;
      last_raw_r    <= 1'b0;
      stable_r      <= 1'b0;
      last_change_r <= '0;
    end else if (in_acc) begin
      mode_r        <= mode_nxt;
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      last_change_r <= last_change_nxt;
    end
  end

  // debounce and mode advance
  always_comb begin
    mode_nxt        = mode_r;
    last_raw_nxt    = last_raw_r;
    stable_nxt      = stable_r;
    last_change_nxt = last_change_r;
    held_ticks      = '0;
    if (!in_obstacle_level) begin
      mode_nxt = MODE_STOP;
    end else begin
      if (in_button_level != last_raw_r) begin
        last_change_nxt = in_now_tick;
        last_raw_nxt    = in_button_level;
      end
      held_ticks = in_now_tick - last_change_nxt;
      if (held_ticks >= TICK_W'(debounce_ticks_r) && in_button_level != stable_r) begin
        stable_nxt = in_button_level;
        if (in_button_level == button_active_r) begin
          case (mode_r)
            MODE_STOP:    mode_nxt = MODE_FORWARD;
            MODE_FORWARD: mode_nxt = MODE_REVERSE;
            MODE_REVERSE: mode_nxt = MODE_LEFT;
            MODE_LEFT:    mode_nxt = MODE_RIGHT;
            default:      mode_nxt = MODE_STOP;
          endcase
        end
      end
    end
  end

  assign res_active = (mode_nxt == MODE_FORWARD) || (mode_nxt == MODE_REVERSE) ||
                      (mode_nxt == MODE_LEFT) || (mode_nxt == MODE_RIGHT);

  mmdc_bridge_map u_bridge (
    .mode      (mode_nxt),
    .m2_invert (m2_invert_r),
    .bridge    (res_bridge)
  );

  mmdc_duty_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DUTY_BITS   (DUTY_BITS)
  ) u_duty (
    .sample (in_light_sample),
    .invert (light_invert_r),
    .enable (res_active),
    .duty   (res_duty)
  );

  // output word and skid word valid flags
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_load) begin
      out_valid_nxt  = skid_valid_r || in_acc;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_mode_r   <= skid_mode_r;
        out_bridge_r <= skid_bridge_r;
        out_duty_r   <= skid_duty_r;
      end else if (in_acc) begin
        out_mode_r   <= mode_nxt;
        out_bridge_r <= res_bridge;
        out_duty_r   <= res_duty;
      end
    end else if (in_acc) begin
      skid_mode_r   <= mode_nxt;
      skid_bridge_r <= res_bridge;
      skid_duty_r   <= res_duty;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_mode    = out_mode_r;
  assign out_motor_one_fwd = out_bridge_r.m1_fwd;
  assign out_motor_one_rev = out_bridge_r.m1_rev;
  assign out_motor_two_fwd = out_bridge_r.m2_fwd;
  assign out_motor_two_rev = out_bridge_r.m2_rev;
  assign out_pwm_duty      = out_duty_r;

  // skid word only exists behind a held output word
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word valid without output word");

  // an obstacle poll forces stop
  a_obstacle_stop : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_obstacle_level) |=> (mode_r == MODE_STOP))
    else $error("obstacle did not force stop");

  // a stop result drives nothing
  a_stop_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == MODE_STOP) |->
      (out_duty_r == '0 && out_bridge_r == '0))
    else $error("stop result with drive active");

endmodule

// ===== tb/motor_mode_drive_controller_top_test.sv =====
// ----------------------------------------------------------------------------
// motor_mode_drive_controller_top_test
// Self-checking bench for the debounced mode cycler and H-bridge drive.
// A directed table covers reset, obstacle, debounce edges, timestamp wrap,
// zero debounce and each register. Random button press sequences follow,
// under several register settings. Each result word is held to a table
// word or software copy of the controller; both channels idle at random.
// ----------------------------------------------------------------------------
module motor_mode_drive_controller_top_test;
  import mmdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_POLLS    = 155;

  typedef struct packed {
    logic [2:0] drive_mode;
    bridge_t    bridge;
    logic [9:0] pwm_duty;
  } drive_word_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_data;
    logic [11:0] sample;
    logic        obstacle;
    logic        button;
    logic [31:0] tick;
    bit          typed;
    drive_word_t want;
  } poll_row_t;

  localparam drive_word_t STOP_WORD = '0;
  localparam drive_word_t FWD_FULL  = '{drive_mode: MODE_FORWARD, bridge: 4'b1001,
                                        pwm_duty: 10'd1023};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] in_light_sample;
  logic        in_obstacle_level;
  logic        in_button_level;
  logic [31:0] in_now_tick;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_drive_mode;
  logic        out_motor_one_fwd;
  logic        out_motor_one_rev;
  logic        out_motor_two_fwd;
  logic        out_motor_two_rev;
  logic [9:0]  out_pwm_duty;

  motor_mode_drive_controller_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_light_sample   (in_light_sample),
    .in_obstacle_level (in_obstacle_level),
    .in_button_level   (in_button_level),
    .in_now_tick       (in_now_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_mode    (out_drive_mode),
    .out_motor_one_fwd (out_motor_one_fwd),
    .out_motor_one_rev (out_motor_one_rev),
    .out_motor_two_fwd (out_motor_two_fwd),
    .out_motor_two_rev (out_motor_two_rev),
    .out_pwm_duty      (out_pwm_duty)
  );

  // predictor state and register copies
  mode_t       pm_mode;
  logic        pm_last_raw;
  logic        pm_stable;
  logic [31:0] pm_last_change;
  logic [15:0] cf_debounce;
  logic        cf_light_inv;
  logic        cf_m2_inv;
  logic        cf_active;

  drive_word_t expected_drive_q[$];
  poll_row_t   poll_table[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          quiet;
  bit          hold_req;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic drive_word_t drive_predict(input logic [11:0] s, input logic obs,
                                                input logic btn, input logic [31:0] now);
    drive_word_t r;
    int          d1;
    int          d2;
    logic [11:0] smp;
    logic [31:0] elapsed;
    int unsigned scaled;
    if (!obs) begin
      pm_mode = MODE_STOP;
    end else begin
      if (btn != pm_last_raw) begin
        pm_last_change = now;
        pm_last_raw    = btn;
      end
      elapsed = now - pm_last_change;
      if (elapsed >= {16'd0, cf_debounce} && btn != pm_stable) begin
        pm_stable = btn;
        if (pm_stable == cf_active)
          pm_mode = (pm_mode == MODE_RIGHT) ? MODE_STOP : mode_t'(pm_mode + 3'd1);
      end
    end
    case (pm_mode)
      MODE_FORWARD: begin d1 = 1;  d2 = 1;  end
      MODE_REVERSE: begin d1 = -1; d2 = -1; end
      MODE_LEFT:    begin d1 = -1; d2 = 1;  end
      MODE_RIGHT:   begin d1 = 1;  d2 = -1; end
      default:      begin d1 = 0;  d2 = 0;  end
    endcase
    if (cf_m2_inv) d2 = -d2;
    smp    = cf_light_inv ? (12'hFFF - s) : s;
    scaled = (int'(smp) * 1023) / 4095;
    r.drive_mode    = pm_mode;
    r.bridge.m1_fwd = (d1 > 0);
    r.bridge.m1_rev = (d1 < 0);
    r.bridge.m2_fwd = (d2 > 0);
    r.bridge.m2_rev = (d2 < 0);
    r.pwm_duty      = (pm_mode != MODE_STOP) ? 10'(scaled) : 10'd0;
    return r;
  endfunction

  task automatic add_row(input logic [11:0] s, input logic obs, input logic btn,
                         input logic [31:0] t, input bit typed, input drive_word_t want);
    poll_row_t row;
    row = '{is_cfg: 1'b0, reg_idx: '0, reg_data: '0, sample: s, obstacle: obs,
            button: btn, tick: t, typed: typed, want: want};
    poll_table.push_back(row);
  endtask

  task automatic add_cfg_row(input logic [1:0] idx, input logic [15:0] data);
    poll_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_data: data, sample: '0, obstacle: 1'b1,
            button: 1'b0, tick: '0, typed: 1'b0, want: STOP_WORD};
    poll_table.push_back(row);
  endtask

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic offer_poll(input logic [11:0] s, input logic obs, input logic btn,
                            input logic [31:0] t, input bit typed, input drive_word_t want);
    drive_word_t pred;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 23) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_light_sample   <= s;
    in_obstacle_level <= obs;
    in_button_level   <= btn;
    in_now_tick       <= t;
    do @(posedge clk); while (in_stall);
    pred = drive_predict(s, obs, btn, t);
    expected_drive_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // hold the sender until every result word is back, plus latency slack
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // one write strobe with cfg_we low after it, so back to back writes stay apart
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_TICKS: cf_debounce  = data;
      CFG_LIGHT_INVERT:   cf_light_inv = data[0];
      CFG_MOTOR_TWO_INV:  cf_m2_inv    = data[0];
      CFG_BUTTON_ACTIVE:  cf_active    = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // receiver: random stall, quiet stretch, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 23);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drive_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, mode %0d duty %0d", $time,
                 out_drive_mode, out_pwm_duty);
      end else begin
        drive_word_t w;
        w = expected_drive_q.pop_front();
        check_field("drive_mode", w.drive_mode, out_drive_mode);
        check_field("motor_one_fwd", w.bridge.m1_fwd, out_motor_one_fwd);
        check_field("motor_one_rev", w.bridge.m1_rev, out_motor_one_rev);
        check_field("motor_two_fwd", w.bridge.m2_fwd, out_motor_two_fwd);
        check_field("motor_two_rev", w.bridge.m2_rev, out_motor_two_rev);
        check_field("pwm_duty", w.pwm_duty, out_pwm_duty);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] rnd_tick;
    logic        rnd_level;
    int          hold_left;
    logic        btn;
    logic        obs;
    logic [11:0] smp;
    int          pick;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_addr          = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_light_sample   = '0;
    in_obstacle_level = 1'b1;
    in_button_level   = 1'b0;
    in_now_tick       = '0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    pm_mode           = MODE_STOP;
    pm_last_raw       = 1'b0;
    pm_stable         = 1'b0;
    pm_last_change    = '0;
    cf_debounce       = 16'd40;
    cf_light_inv      = 1'b0;
    cf_m2_inv         = 1'b1;
    cf_active         = 1'b1;

    // reset state, press held exactly the debounce time, obstacle
    add_row(12'd0,    1, 0, 32'd0,   1, STOP_WORD);
    add_row(12'd4095, 1, 1, 32'd100, 1, STOP_WORD);
    add_row(12'd4095, 1, 1, 32'd140, 1, FWD_FULL);
    add_row(12'd0,    0, 1, 32'd141, 1, STOP_WORD);
    add_row(12'd2048, 1, 0, 32'd150, 0, STOP_WORD);
    add_row(12'd2048, 1, 0, 32'd189, 0, STOP_WORD);
    add_row(12'd2048, 1, 0, 32'd190, 0, STOP_WORD);
    add_row(12'd1,    1, 1, 32'd200, 0, STOP_WORD);
    add_row(12'd1,    1, 1, 32'd240, 0, STOP_WORD);
    add_row(12'd4094, 1, 0, 32'd241, 0, STOP_WORD);
    add_row(12'd4094, 1, 0, 32'd281, 0, STOP_WORD);
    add_row(12'd4094, 1, 1, 32'd290, 0, STOP_WORD);
    add_row(12'd4094, 1, 1, 32'd330, 0, STOP_WORD);
    // timestamp wraps between change and hold
    add_row(12'd3000, 1, 0, 32'hFFFF_FFF0, 0, STOP_WORD);
    add_row(12'd3000, 1, 0, 32'h0000_0018, 0, STOP_WORD);
    add_row(12'd3000, 1, 1, 32'h0000_0020, 0, STOP_WORD);
    add_row(12'd3000, 1, 1, 32'h0000_0048, 0, STOP_WORD);
    // zero debounce: level stable on first sight
    add_cfg_row(CFG_DEBOUNCE_TICKS, 16'd0);
    add_row(12'd100,  1, 0, 32'h0000_0050, 0, STOP_WORD);
    add_row(12'd100,  1, 1, 32'h0000_0051, 0, STOP_WORD);
    add_row(12'd100,  1, 0, 32'h0000_0052, 0, STOP_WORD);
    add_row(12'd100,  1, 1, 32'h0000_0053, 0, STOP_WORD);
    add_cfg_row(CFG_LIGHT_INVERT, 16'd1);
    add_row(12'd0,    1, 0, 32'h0000_0054, 0, STOP_WORD);
    add_row(12'd0,    1, 1, 32'h0000_0055, 0, STOP_WORD);
    add_cfg_row(CFG_MOTOR_TWO_INV, 16'd0);
    add_row(12'd4095, 1, 1, 32'h0000_0056, 0, STOP_WORD);
    add_cfg_row(CFG_BUTTON_ACTIVE, 16'd0);
    add_row(12'd2000, 1, 0, 32'h0000_0057, 0, STOP_WORD);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (poll_table[i]) begin
      if (poll_table[i].is_cfg) begin
        drain_results();
        write_reg(poll_table[i].reg_idx, poll_table[i].reg_data);
      end else begin
        offer_poll(poll_table[i].sample, poll_table[i].obstacle, poll_table[i].button,
                   poll_table[i].tick, poll_table[i].typed, poll_table[i].want);
      end
    end

    rnd_tick  = 32'h0000_1000;
    rnd_level = pm_last_raw;
    hold_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(CFG_DEBOUNCE_TICKS, 16'd40);
          write_reg(CFG_LIGHT_INVERT, 16'd0);
          write_reg(CFG_MOTOR_TWO_INV, 16'd1);
          write_reg(CFG_BUTTON_ACTIVE, 16'd1);
        end
        1: begin
          write_reg(CFG_DEBOUNCE_TICKS, 16'd0);
          write_reg(CFG_LIGHT_INVERT, 16'd1);
          write_reg(CFG_MOTOR_TWO_INV, 16'd0);
          write_reg(CFG_BUTTON_ACTIVE, 16'd0);
        end
        2: begin
          write_reg(CFG_DEBOUNCE_TICKS, 16'hFFFF);
          write_reg(CFG_LIGHT_INVERT, 16'd0);
          write_reg(CFG_MOTOR_TWO_INV, 16'd0);
          write_reg(CFG_BUTTON_ACTIVE, 16'd1);
        end
        3: begin
          write_reg(CFG_DEBOUNCE_TICKS, 16'd1);
          write_reg(CFG_LIGHT_INVERT, 16'hFFFF);
          write_reg(CFG_MOTOR_TWO_INV, 16'hFFFF);
          write_reg(CFG_BUTTON_ACTIVE, 16'hFFFE);
        end
        default: begin
          write_reg(CFG_DEBOUNCE_TICKS, 16'($urandom_range(0, 200)));
          write_reg(CFG_LIGHT_INVERT, 16'($urandom_range(0, 1)));
          write_reg(CFG_MOTOR_TWO_INV, 16'($urandom_range(0, 1)));
          write_reg(CFG_BUTTON_ACTIVE, 16'($urandom_range(0, 1)));
        end
      endcase
      quiet = (p == 2);
      for (int k = 0; k < PHASE_POLLS; k++) begin
        if (p == 4 && k == 50) hold_req = 1'b1;
        if (p == 6 && k == 70) drain_results();
        // press sequences: hold a level for 2 to 10 polls, with short bounces
        if (hold_left == 0) begin
          rnd_level = ~rnd_level;
          hold_left = $urandom_range(2, 10);
        end
        hold_left--;
        btn = rnd_level;
        if ($urandom_range(0, 99) < 8) btn = ~btn;
        rnd_tick = rnd_tick + $urandom_range(0, cf_debounce / 3 + 2);
        if ($urandom_range(0, 99) < 3) rnd_tick = $urandom;
        obs  = ($urandom_range(0, 99) >= 8);
        pick = $urandom_range(0, 9);
        smp  = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
        offer_poll(smp, obs, btn, rnd_tick, 1'b0, STOP_WORD);
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
